@@ rtl/pfmws_pkg.sv @@
package pfmws_pkg;

    // fixed field widths
    localparam int CFG_BITS = 10;
    localparam int OUT_BITS = 48;

    // defaults for the top level parameters
    localparam int DEF_MAX_HALF_PERIOD = 512;
    localparam int DEF_SAMPLE_BITS     = 32;
    localparam int DEF_ACC_BITS        = 48;

    // issue flags that travel with the memory read data into the window unit
    typedef struct packed {
        logic init;   // clear running sum and minimum
        logic sum0;   // add port a into the first window
        logic slide;  // add port a, subtract port b, then compare
    } walk_ctl_t;

endpackage

@@ rtl/periodic_fold_min_window_sum.sv @@
// Folds a set of signed samples into 2*w phase accumulators held in one
// synchronous memory (w from half_period, 0 taken as 1, values above
// MAX_HALF_PERIOD taken as MAX_HALF_PERIOD), each accumulator saturating.
// Samples transfer at one per cycle while in_ready is high (in the load
// state); each is a read-modify-write of the memory entry of its phase,
// the write landing in the following cycle. After the sample marked last,
// the block walks the memory: a flush step, the first window, sliding it
// with the two read ports, pipeline drain and loading the result, then
// clearing the entries the slide could not clear. The result is the
// least circular window sum, saturated to 48 bits, and waits in an output
// register while the next set loads; if it is still waiting when the next
// walk ends, the load cycle holds until it is taken. After reset and after
// every half_period write (which drops any partial set) a clearing pass
// over all 2*MAX_HALF_PERIOD entries runs before samples are taken.
module periodic_fold_min_window_sum
    import pfmws_pkg::*;
#(
    parameter int MAX_HALF_PERIOD = DEF_MAX_HALF_PERIOD,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    parameter int ACC_BITS        = DEF_ACC_BITS
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_BITS-1:0]           half_period,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OUT_BITS-1:0]    minimum_sum
);

    localparam int PHASES    = 2 * MAX_HALF_PERIOD;
    localparam int ADDR_BITS = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam int CNT_BITS  = ADDR_BITS + 1;
    localparam int SUM_BITS  = ACC_BITS + $clog2(MAX_HALF_PERIOD) + 1;
    localparam int ADD_BITS  = ((ACC_BITS > SAMPLE_BITS) ? ACC_BITS : SAMPLE_BITS) + 1;
    localparam logic signed [ADD_BITS-1:0] ACC_MAX_W =
        ADD_BITS'((64'(1) << (ACC_BITS-1)) - 64'(1));
    localparam logic signed [ADD_BITS-1:0] ACC_MIN_W = -ACC_MAX_W - ADD_BITS'(1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_FLUSH,
        ST_SUM0,
        ST_SLIDE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                      state_reg;
    logic [CNT_BITS-1:0]         w_reg;
    logic [CNT_BITS-1:0]         period_reg;
    logic [CNT_BITS-1:0]         w_next;
    logic [ADDR_BITS-1:0]        pos_reg;
    logic [ADDR_BITS-1:0]        pos_next;
    logic [CNT_BITS-1:0]         pos_inc;
    logic [ADDR_BITS-1:0]        walk_cnt_reg;
    logic [CNT_BITS-1:0]         walk_ext;
    logic [ADDR_BITS-1:0]        clr_cnt_reg;
    logic [CNT_BITS-1:0]         clr_lim_reg;
    logic                        pend_reg;
    logic [ADDR_BITS-1:0]        pend_addr_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    walk_ctl_t                   ctl_q_reg;
    logic                        out_valid_reg;
    logic signed [OUT_BITS-1:0]  minimum_sum_reg;

    logic                        in_fire;
    logic                        out_load;
    logic                        walk_busy;
    logic signed [OUT_BITS-1:0]  walk_result;
    logic                        slide_low;
    logic [ADDR_BITS-1:0]        slide_a;
    logic signed [ADD_BITS-1:0]  sum_w;
    logic signed [ACC_BITS-1:0]  sat_val;

    logic signed [ACC_BITS-1:0]  acc_mem [PHASES];
    logic                        wr_en;
    logic [ADDR_BITS-1:0]        wr_addr;
    logic signed [ACC_BITS-1:0]  wr_data;
    logic [ADDR_BITS-1:0]        rd_a_addr;
    logic [ADDR_BITS-1:0]        rd_b_addr;
    logic signed [ACC_BITS-1:0]  rd_a_reg;
    logic signed [ACC_BITS-1:0]  rd_b_reg;

    assign in_ready    = (state_reg == ST_LOAD);
    assign in_fire     = in_valid & in_ready;
    assign out_valid   = out_valid_reg;
    assign minimum_sum = minimum_sum_reg;
    assign out_load    = (state_reg == ST_FINISH) && !cfg_we && (!out_valid_reg || out_ready);

    // effective window length from the register value
    always_comb
    begin
        priority if (half_period == '0)
        begin
            w_next = CNT_BITS'(1);
        end
        else if (int'(half_period) > MAX_HALF_PERIOD)
        begin
            w_next = CNT_BITS'(MAX_HALF_PERIOD);
        end
        else
        begin
            w_next = CNT_BITS'(half_period);
        end
    end

    // phase position and slide addresses
    always_comb
    begin
        pos_inc   = {1'b0, pos_reg} + CNT_BITS'(1);
        pos_next  = (pos_inc == period_reg) ? '0 : ADDR_BITS'(pos_inc);
        walk_ext  = {1'b0, walk_cnt_reg};
        slide_low = (walk_ext < w_reg);
        if (slide_low)
        begin
            slide_a = ADDR_BITS'(walk_ext + w_reg);
        end
        else
        begin
            slide_a = ADDR_BITS'(walk_ext - w_reg);
        end
    end

    // saturating add for the pending read-modify-write
    always_comb
    begin
        sum_w = ADD_BITS'(rd_a_reg) + ADD_BITS'(samp_reg);
        priority if (sum_w > ACC_MAX_W)
        begin
            sat_val = ACC_BITS'(ACC_MAX_W);
        end
        else if (sum_w < ACC_MIN_W)
        begin
            sat_val = ACC_BITS'(ACC_MIN_W);
        end
        else
        begin
            sat_val = ACC_BITS'(sum_w);
        end
    end

    // write port: clearing first, then slide clearing, then sample update
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = sat_val;
        priority if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if ((state_reg == ST_SLIDE) && !slide_low)
        begin
            wr_en   = 1'b1;
            wr_addr = walk_cnt_reg;
            wr_data = '0;
        end
        else if (pend_reg)
        begin
            wr_en = 1'b1;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    // read addresses
    always_comb
    begin
        rd_b_addr = walk_cnt_reg;
        unique case (state_reg)
            ST_LOAD:  rd_a_addr = pos_reg;
            ST_SLIDE: rd_a_addr = slide_a;
            default:  rd_a_addr = walk_cnt_reg;
        endcase
    end

    // accumulator memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            acc_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= acc_mem[rd_a_addr];
        rd_b_reg <= acc_mem[rd_b_addr];
    end

    // sample and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            samp_reg      <= sample;
            pend_addr_reg <= pos_reg;
        end
        if (out_load)
        begin
            minimum_sum_reg <= walk_result;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            w_reg         <= CNT_BITS'(1);
            period_reg    <= CNT_BITS'(2);
            pos_reg       <= '0;
            walk_cnt_reg  <= '0;
            clr_cnt_reg   <= '0;
            clr_lim_reg   <= CNT_BITS'(PHASES);
            pend_reg      <= 1'b0;
            ctl_q_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= in_fire;
            ctl_q_reg <= '0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                w_reg       <= w_next;
                period_reg  <= CNT_BITS'({w_next, 1'b0});
                pos_reg     <= '0;
                clr_cnt_reg <= '0;
                clr_lim_reg <= CNT_BITS'(PHASES);
                state_reg   <= ST_CLEAR;
            end
            else
            begin
                unique case (state_reg)
                    ST_CLEAR:
                    begin
                        if ({1'b0, clr_cnt_reg} == clr_lim_reg - CNT_BITS'(1))
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
                        end
                    end
                    ST_LOAD:
                    begin
                        if (in_fire)
                        begin
                            if (last_sample)
                            begin
                                pos_reg   <= '0;
                                state_reg <= ST_FLUSH;
                            end
                            else
                            begin
                                pos_reg <= pos_next;
                            end
                        end
                    end
                    ST_FLUSH:
                    begin
                        ctl_q_reg.init <= 1'b1;
                        walk_cnt_reg   <= '0;
                        state_reg      <= ST_SUM0;
                    end
                    ST_SUM0:
                    begin
                        ctl_q_reg.sum0 <= 1'b1;
                        if (walk_ext == w_reg - CNT_BITS'(1))
                        begin
                            walk_cnt_reg <= '0;
                            state_reg    <= ST_SLIDE;
                        end
                        else
                        begin
                            walk_cnt_reg <= walk_cnt_reg + ADDR_BITS'(1);
                        end
                    end
                    ST_SLIDE:
                    begin
                        ctl_q_reg.slide <= 1'b1;
                        if (walk_ext == period_reg - CNT_BITS'(1))
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            walk_cnt_reg <= walk_cnt_reg + ADDR_BITS'(1);
                        end
                    end
                    ST_DRAIN:
                    begin
                        if (!walk_busy)
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                    ST_FINISH:
                    begin
                        if (out_load)
                        begin
                            out_valid_reg <= 1'b1;
                            clr_cnt_reg   <= '0;
                            clr_lim_reg   <= w_reg;
                            state_reg     <= ST_CLEAR;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_CLEAR;
                    end
                endcase
            end
        end
    end

    // window sum and running minimum
    pfmws_window_min #(
        .ACC_BITS (ACC_BITS),
        .SUM_BITS (SUM_BITS)
    ) u_window_min (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_q_reg),
        .rd_a   (rd_a_reg),
        .rd_b   (rd_b_reg),
        .busy   (walk_busy),
        .result (walk_result)
    );

    // samples only transfer once the window pipeline is empty
    a_load_idle_walk: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !walk_busy)
        else $error("sample taken while window walk still running");

    // phase position stays inside the folding period
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < period_reg)
        else $error("phase position outside folding period");

    // walk addresses stay inside the folding period
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM0 || state_reg == ST_SLIDE) |-> walk_ext < period_reg)
        else $error("walk counter outside folding period");

    // clearing pass stays below its limit
    a_clear_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> ({1'b0, clr_cnt_reg} < clr_lim_reg))
        else $error("clear counter beyond limit");

endmodule

@@ rtl/pfmws_window_min.sv @@
module pfmws_window_min
    import pfmws_pkg::*;
#(
    parameter int ACC_BITS = DEF_ACC_BITS,
    parameter int SUM_BITS = DEF_ACC_BITS + 10
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  walk_ctl_t                  ctl,
    input  logic signed [ACC_BITS-1:0] rd_a,
    input  logic signed [ACC_BITS-1:0] rd_b,
    output logic                       busy,
    output logic signed [OUT_BITS-1:0] result
);

    localparam int EXT_BITS = (SUM_BITS > OUT_BITS) ? SUM_BITS : OUT_BITS;
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [EXT_BITS-1:0] OUT_MAX_E =
        EXT_BITS'((64'(1) << (OUT_BITS-1)) - 64'(1));
    localparam logic signed [EXT_BITS-1:0] OUT_MIN_E = -OUT_MAX_E - EXT_BITS'(1);

    logic                       d_valid_reg;
    logic                       d_slide_reg;
    logic                       b_slide_reg;
    logic signed [ACC_BITS:0]   diff_reg;
    logic signed [SUM_BITS-1:0] bucket_reg;
    logic signed [SUM_BITS-1:0] best_reg;
    logic signed [EXT_BITS-1:0] best_ext;

    // difference stage, running window sum, then running minimum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            d_slide_reg <= 1'b0;
            b_slide_reg <= 1'b0;
            diff_reg    <= '0;
            bucket_reg  <= '0;
            best_reg    <= SUM_MAX;
        end
        else
        begin
            d_valid_reg <= ctl.sum0 | ctl.slide;
            d_slide_reg <= ctl.slide;
            if (ctl.slide)
            begin
                diff_reg <= (ACC_BITS+1)'(rd_a) - (ACC_BITS+1)'(rd_b);
            end
            else
            begin
                diff_reg <= (ACC_BITS+1)'(rd_a);
            end

            b_slide_reg <= d_valid_reg & d_slide_reg;
            if (ctl.init)
            begin
                bucket_reg <= '0;
            end
            else if (d_valid_reg)
            begin
                bucket_reg <= bucket_reg + SUM_BITS'(diff_reg);
            end

            if (ctl.init)
            begin
                best_reg <= SUM_MAX;
            end
            else if (b_slide_reg && (bucket_reg < best_reg))
            begin
                best_reg <= bucket_reg;
            end
        end
    end

    assign busy = ctl.sum0 | ctl.slide | d_valid_reg | b_slide_reg;

    // clamp the minimum to the output range
    always_comb
    begin
        best_ext = EXT_BITS'(best_reg);
        priority if (best_ext < OUT_MIN_E)
        begin
            result = OUT_BITS'(OUT_MIN_E);
        end
        else if (best_ext > OUT_MAX_E)
        begin
            result = OUT_BITS'(OUT_MAX_E);
        end
        else
        begin
            result = OUT_BITS'(best_ext);
        end
    end

    // minimum only moves down between two starts
    a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.init |=> best_reg <= $past(best_reg))
        else $error("window minimum grew without a restart");

    // a new walk starts only with an empty pipeline
    a_init_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.init |-> (!d_valid_reg && !b_slide_reg))
        else $error("walk restarted while window pipeline busy");

endmodule
